[hdl/text_escape_encoder_macros.svh]
// assertion helpers shared by the encoder modules
// each expects i_clk and i_rst_n in the enclosing module
`ifndef TEXT_ESCAPE_ENCODER_MACROS_SVH
`define TEXT_ESCAPE_ENCODER_MACROS_SVH

// same-cycle implication
`define TEE_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("tee assertion failed");

// next-cycle implication
`define TEE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("tee assertion failed");

`endif

[hdl/tee_pkg.sv]
package tee_pkg;

    localparam int ByteW = 8;
    localparam int IdxW  = 3;

    // escape modes
    localparam logic [1:0] MODE_HTML     = 2'd0;
    localparam logic [1:0] MODE_STR_HTML = 2'd1;
    localparam logic [1:0] MODE_STR      = 2'd2;

    // character codes
    localparam logic [ByteW-1:0] CH_AMP    = 8'h26;
    localparam logic [ByteW-1:0] CH_QUOTE  = 8'h22;
    localparam logic [ByteW-1:0] CH_APOS   = 8'h27;
    localparam logic [ByteW-1:0] CH_LT     = 8'h3C;
    localparam logic [ByteW-1:0] CH_GT     = 8'h3E;
    localparam logic [ByteW-1:0] CH_BSLASH = 8'h5C;
    localparam logic [ByteW-1:0] CH_PLUS   = 8'h2B;
    localparam logic [ByteW-1:0] CH_SEMI   = 8'h3B;
    localparam logic [ByteW-1:0] CH_A      = 8'h61;
    localparam logic [ByteW-1:0] CH_G      = 8'h67;
    localparam logic [ByteW-1:0] CH_L      = 8'h6C;
    localparam logic [ByteW-1:0] CH_M      = 8'h6D;
    localparam logic [ByteW-1:0] CH_O      = 8'h6F;
    localparam logic [ByteW-1:0] CH_P      = 8'h70;
    localparam logic [ByteW-1:0] CH_Q      = 8'h71;
    localparam logic [ByteW-1:0] CH_S      = 8'h73;
    localparam logic [ByteW-1:0] CH_T      = 8'h74;
    localparam logic [ByteW-1:0] CH_U      = 8'h75;

    typedef enum logic [3:0] {
        SEQ_PASS,
        SEQ_AMP,
        SEQ_QUOT,
        SEQ_APOS,
        SEQ_LT,
        SEQ_GT,
        SEQ_BS_QUOTE,
        SEQ_BS_BSLASH,
        SEQ_STR_LT
    } t_seq;

    typedef struct packed {
        logic             valid;
        t_seq             seq;
        logic [ByteW-1:0] raw;
    } t_item;

    function automatic logic [IdxW-1:0] seq_len(input t_seq s);
        logic [IdxW-1:0] len;
        unique case (s)
            SEQ_AMP:                    len = 3'd5;
            SEQ_QUOT, SEQ_APOS:         len = 3'd6;
            SEQ_LT, SEQ_GT, SEQ_STR_LT: len = 3'd4;
            SEQ_BS_QUOTE, SEQ_BS_BSLASH: len = 3'd2;
            default:                    len = 3'd1;
        endcase
        return len;
    endfunction

    function automatic logic [ByteW-1:0] seq_byte(input t_seq s, input logic [IdxW-1:0] i,
                                                  input logic [ByteW-1:0] raw);
        logic [ByteW-1:0] b;
        b = raw;
        unique case (s)
            SEQ_AMP: begin
                unique case (i)
                    3'd0:    b = CH_AMP;
                    3'd1:    b = CH_A;
                    3'd2:    b = CH_M;
                    3'd3:    b = CH_P;
                    default: b = CH_SEMI;
                endcase
            end
            SEQ_QUOT: begin
                unique case (i)
                    3'd0:    b = CH_AMP;
                    3'd1:    b = CH_Q;
                    3'd2:    b = CH_U;
                    3'd3:    b = CH_O;
                    3'd4:    b = CH_T;
                    default: b = CH_SEMI;
                endcase
            end
            SEQ_APOS: begin
                unique case (i)
                    3'd0:    b = CH_AMP;
                    3'd1:    b = CH_A;
                    3'd2:    b = CH_P;
                    3'd3:    b = CH_O;
                    3'd4:    b = CH_S;
                    default: b = CH_SEMI;
                endcase
            end
            SEQ_LT: begin
                unique case (i)
                    3'd0:    b = CH_AMP;
                    3'd1:    b = CH_L;
                    3'd2:    b = CH_T;
                    default: b = CH_SEMI;
                endcase
            end
            SEQ_GT: begin
                unique case (i)
                    3'd0:    b = CH_AMP;
                    3'd1:    b = CH_G;
                    3'd2:    b = CH_T;
                    default: b = CH_SEMI;
                endcase
            end
            SEQ_BS_QUOTE:  b = (i == 3'd0) ? CH_BSLASH : CH_QUOTE;
            SEQ_BS_BSLASH: b = CH_BSLASH;
            SEQ_STR_LT: begin
                unique case (i)
                    3'd0:    b = CH_LT;
                    3'd2:    b = CH_PLUS;
                    default: b = CH_QUOTE;
                endcase
            end
            default: b = raw;
        endcase
        return b;
    endfunction

endpackage

[hdl/tee_classify.sv]
module tee_classify (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [1:0]           i_mode,
    input  logic                 i_valid,
    output logic                 o_ready,
    input  logic [7:0]           i_byte,
    input  logic                 i_eos,
    output tee_pkg::t_item       o_item,
    input  logic                 i_take
);
    import tee_pkg::*;

    `include "text_escape_encoder_macros.svh"

    logic             r_iv;
    logic [ByteW-1:0] r_ib;
    logic             r_ie;
    logic             r_flag;
    logic             n_flag;
    logic             accept;
    t_seq             seq;

    assign o_ready = !r_iv || i_take;
    assign accept  = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_iv <= 1'b0;
        end else if (accept) begin
            r_iv <= 1'b1;
        end else if (i_take) begin
            r_iv <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_ib <= i_byte;
            r_ie <= i_eos;
        end
    end

    // escape selection for the held byte
    always_comb begin
        seq = SEQ_PASS;
        if (!r_ib[ByteW-1] && !r_flag) begin
            if (i_mode == MODE_HTML) begin
                unique case (r_ib)
                    CH_AMP:   seq = SEQ_AMP;
                    CH_QUOTE: seq = SEQ_QUOT;
                    CH_APOS:  seq = SEQ_APOS;
                    CH_LT:    seq = SEQ_LT;
                    CH_GT:    seq = SEQ_GT;
                    default:  seq = SEQ_PASS;
                endcase
            end else if (i_mode == MODE_STR_HTML || i_mode == MODE_STR) begin
                priority if (r_ib == CH_QUOTE) begin
                    seq = SEQ_BS_QUOTE;
                end else if (r_ib == CH_BSLASH) begin
                    seq = SEQ_BS_BSLASH;
                end else if (r_ib == CH_LT && i_mode == MODE_STR_HTML) begin
                    seq = SEQ_STR_LT;
                end else begin
                    seq = SEQ_PASS;
                end
            end
        end
    end

    always_comb begin
        n_flag = r_flag;
        if (r_ib[ByteW-1]) begin
            n_flag = 1'b1;
        end else if (r_flag) begin
            n_flag = 1'b0;
        end
        if (r_ie) begin
            n_flag = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag <= 1'b0;
        end else if (i_take && r_iv) begin
            r_flag <= n_flag;
        end
    end

    assign o_item = '{valid: r_iv, seq: seq, raw: r_ib};

    `TEE_ASSERT_NEXT(a_eos_clears_flag, i_take && r_iv && r_ie, !r_flag)
    `TEE_ASSERT_NEXT(a_top_bit_sets_flag, i_take && r_iv && r_ib[7] && !r_ie, r_flag)
    `TEE_ASSERT_NOW(a_flag_blocks_escape, r_iv && (r_flag || r_ib[7]), seq == SEQ_PASS)

endmodule

[hdl/tee_emit.sv]
module tee_emit (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  tee_pkg::t_item       i_item,
    output logic                 o_take,
    output logic                 o_tvalid,
    input  logic                 i_tready,
    output logic [7:0]           o_tdata,
    output logic                 o_tlast
);
    import tee_pkg::*;

    `include "text_escape_encoder_macros.svh"

    logic             r_ov;
    logic [ByteW-1:0] r_byte;
    logic             r_last;
    t_seq             r_seq;
    logic [IdxW-1:0]  r_idx;
    logic [ByteW-1:0] r_raw;

    logic             n_ov;
    logic [ByteW-1:0] n_byte;
    logic             n_last;
    t_seq             n_seq;
    logic [IdxW-1:0]  n_idx;
    logic [ByteW-1:0] n_raw;

    logic advance;
    logic more;

    assign advance = !r_ov || i_tready;
    assign more    = r_ov && !r_last;
    assign o_take  = advance && !more && i_item.valid;

    always_comb begin
        n_ov   = r_ov;
        n_byte = r_byte;
        n_last = r_last;
        n_seq  = r_seq;
        n_idx  = r_idx;
        n_raw  = r_raw;
        if (advance) begin
            if (more) begin
                n_idx  = r_idx + 3'd1;
                n_byte = seq_byte(r_seq, n_idx, r_raw);
                n_last = (n_idx == seq_len(r_seq) - 3'd1);
            end else if (i_item.valid) begin
                n_ov   = 1'b1;
                n_seq  = i_item.seq;
                n_raw  = i_item.raw;
                n_idx  = '0;
                n_byte = seq_byte(i_item.seq, '0, i_item.raw);
                n_last = (seq_len(i_item.seq) == 3'd1);
            end else begin
                n_ov = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ov <= 1'b0;
        end else begin
            r_ov <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        r_byte <= n_byte;
        r_last <= n_last;
        r_seq  <= n_seq;
        r_idx  <= n_idx;
        r_raw  <= n_raw;
    end

    assign o_tvalid = r_ov;
    assign o_tdata  = r_byte;
    assign o_tlast  = r_last;

    `TEE_ASSERT_NOW(a_idx_in_run, r_ov, r_idx < seq_len(r_seq))
    `TEE_ASSERT_NOW(a_last_at_end, r_ov, r_last == (r_idx == seq_len(r_seq) - 3'd1))
    `TEE_ASSERT_NOW(a_no_take_mid_run, o_take, !r_ov || r_last)

endmodule

[hdl/text_escape_encoder.sv]
// text escape encoder: one text byte per input transaction, one or more escaped
// bytes out, one per output transaction; tlast marks the final byte of each run.
// i_cfg_wr_data picks the escape set (0 html entities, 1 string inside html,
// 2 plain string, 3 no escaping); the user must write it only while the block is
// idle, which the block itself does not enforce. a byte with its top bit set
// raises a multibyte flag; the next byte below 128 then passes unescaped and
// clears it, and a byte with s_axis_tlast clears it too. bytes that pass through
// stream at one per clock while m_axis_tready stays high; an escaped byte's run
// (2 to 6 bytes) leaves the output register one byte at a time, while the input
// register fills and then stalls.
module text_escape_encoder (
    input  logic       i_clk,
    input  logic       i_rst_n,
    // configuration
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,    // escape_mode
    // input stream
    input  logic       s_axis_tvalid,
    output logic       s_axis_tready,
    input  logic [7:0] s_axis_tdata,     // [7:0] in_byte
    input  logic       s_axis_tlast,     // end_of_string
    // output stream
    output logic       m_axis_tvalid,
    input  logic       m_axis_tready,
    output logic [7:0] m_axis_tdata,     // [7:0] out_byte
    output logic       m_axis_tlast      // last_of_run
);
    import tee_pkg::*;

    // escape mode register
    logic [1:0] r_mode;
    // held input byte and its chosen escape run
    t_item      item;
    // emitter pulls the held byte into the output register
    logic       take;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_HTML;
        end else if (i_cfg_wr_en) begin
            r_mode <= i_cfg_wr_data;
        end
    end

    // input register, multibyte flag and escape selection
    tee_classify u_classify (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_mode  (r_mode),
        .i_valid (s_axis_tvalid),
        .o_ready (s_axis_tready),
        .i_byte  (s_axis_tdata),
        .i_eos   (s_axis_tlast),
        .o_item  (item),
        .i_take  (take)
    );

    // output register walking through the escape run
    tee_emit u_emit (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (item),
        .o_take   (take),
        .o_tvalid (m_axis_tvalid),
        .i_tready (m_axis_tready),
        .o_tdata  (m_axis_tdata),
        .o_tlast  (m_axis_tlast)
    );

endmodule

[tb/sv/text_escape_encoder_checker.sv]
module text_escape_encoder_checker
    import tee_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_cfg_wr_en,
    input  logic [1:0] i_cfg_wr_data,
    input  logic       i_in_valid,
    input  logic       i_in_ready,
    input  logic [7:0] i_in_byte,
    input  logic       i_in_eos,
    input  logic       i_out_valid,
    input  logic       i_out_ready,
    input  logic [7:0] i_out_byte,
    input  logic       i_out_last,
    output int         o_mismatches,
    output int         o_outstanding
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } t_esc_byte;

    t_esc_byte  escaped_q[$];
    logic [1:0] mode_r;
    logic       multibyte_r;

    initial begin
        o_mismatches  = 0;
        o_outstanding = 0;
        mode_r        = MODE_HTML;
        multibyte_r   = 1'b0;
    end

    // run bytes given first-in-highest, len bytes long
    function automatic void queue_run(input logic [47:0] chars, input int len);
        t_esc_byte e;
        for (int k = len - 1; k >= 0; k--) begin
            e.ch   = chars[8*k +: 8];
            e.last = (k == 0);
            escaped_q = {escaped_q, e};
        end
    endfunction

    function automatic void expand_byte(input logic [7:0] b, input logic eos);
        if (b[7]) begin
            multibyte_r = 1'b1;
            queue_run(b, 1);
        end else if (multibyte_r) begin
            // continuation byte passes untouched
            multibyte_r = 1'b0;
            queue_run(b, 1);
        end else if (mode_r == MODE_HTML) begin
            case (b)
                CH_AMP:   queue_run({CH_AMP, CH_A, CH_M, CH_P, CH_SEMI}, 5);
                CH_QUOTE: queue_run({CH_AMP, CH_Q, CH_U, CH_O, CH_T, CH_SEMI}, 6);
                CH_APOS:  queue_run({CH_AMP, CH_A, CH_P, CH_O, CH_S, CH_SEMI}, 6);
                CH_LT:    queue_run({CH_AMP, CH_L, CH_T, CH_SEMI}, 4);
                CH_GT:    queue_run({CH_AMP, CH_G, CH_T, CH_SEMI}, 4);
                default:  queue_run(b, 1);
            endcase
        end else if (mode_r == MODE_STR_HTML || mode_r == MODE_STR) begin
            if (b == CH_QUOTE)
                queue_run({CH_BSLASH, CH_QUOTE}, 2);
            else if (b == CH_BSLASH)
                queue_run({CH_BSLASH, CH_BSLASH}, 2);
            else if (b == CH_LT && mode_r == MODE_STR_HTML)
                queue_run({CH_LT, CH_QUOTE, CH_PLUS, CH_QUOTE}, 4);
            else
                queue_run(b, 1);
        end else begin
            queue_run(b, 1);
        end
        if (eos)
            multibyte_r = 1'b0;
    endfunction

    always @(posedge i_clk) begin
        t_esc_byte want;
        if (!i_rst_n) begin
            mode_r      = MODE_HTML;
            multibyte_r = 1'b0;
            escaped_q.delete();
        end else begin
            if (i_cfg_wr_en)
                mode_r = i_cfg_wr_data;
            // compare before predicting so a stray output cannot match a fresh byte
            if (i_out_valid && i_out_ready) begin
                if (escaped_q.size() == 0) begin
                    if (o_mismatches < 10)
                        $display("%0t: unexpected output byte %h last %b",
                                 $realtime, i_out_byte, i_out_last);
                    o_mismatches++;
                end else begin
                    want = escaped_q.pop_front();
                    if (want.ch !== i_out_byte || want.last !== i_out_last) begin
                        if (o_mismatches < 10)
                            $display("%0t: output byte mismatch: expected %h last %b, got %h last %b",
                                     $realtime, want.ch, want.last, i_out_byte, i_out_last);
                        o_mismatches++;
                    end
                end
            end
            if (i_in_valid && i_in_ready)
                expand_byte(i_in_byte, i_in_eos);
        end
        o_outstanding = escaped_q.size();
    end

endmodule

[tb/sv/tb_text_escape_encoder.sv]
module tb_text_escape_encoder;
    timeunit 1ns;
    timeprecision 1ps;
    import tee_pkg::*;

    // the block also accepts the unused code, which turns all escaping off
    localparam logic [1:0] MODE_RAW = 2'd3;

    // escape set used by each random phase, both extremes included
    localparam logic [1:0] PHASE_MODE [8] = '{MODE_HTML, MODE_STR_HTML, MODE_STR, MODE_RAW,
                                              MODE_STR, MODE_HTML, MODE_RAW, MODE_STR_HTML};
    localparam int PHASE_ITEMS = 50;
    localparam int LONG_HOLD   = 80;

    logic       i_clk         = 1'b0;
    logic       i_rst_n       = 1'b0;
    logic       i_cfg_wr_en   = 1'b0;
    logic [1:0] i_cfg_wr_data = MODE_HTML;
    logic       s_axis_tvalid = 1'b0;
    logic       s_axis_tready;
    logic [7:0] s_axis_tdata  = 8'h00;
    logic       s_axis_tlast  = 1'b0;
    logic       m_axis_tvalid;
    logic       m_axis_tready = 1'b0;
    logic [7:0] m_axis_tdata;
    logic       m_axis_tlast;

    int fail_count;
    int pending_count;

    // sender runs a phase with no gaps at all when set
    bit tight;
    // asks the receiver for its one long hold-off
    bit squeeze_req  = 1'b0;
    bit squeeze_done = 1'b0;

    always #5 i_clk = ~i_clk;

    text_escape_encoder dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast)
    );

    text_escape_encoder_checker checker_i (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .i_in_valid    (s_axis_tvalid),
        .i_in_ready    (s_axis_tready),
        .i_in_byte     (s_axis_tdata),
        .i_in_eos      (s_axis_tlast),
        .i_out_valid   (m_axis_tvalid),
        .i_out_ready   (m_axis_tready),
        .i_out_byte    (m_axis_tdata),
        .i_out_last    (m_axis_tlast),
        .o_mismatches  (fail_count),
        .o_outstanding (pending_count)
    );

    // idle length: mostly none or short, now and then a long one
    function automatic int pick_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 96)
            return $urandom_range(4, 12);
        else
            return $urandom_range(20, 50);
    endfunction

    // one input transaction; returns after acceptance and any random pause
    task automatic send_text_byte(input logic [7:0] b, input logic eos);
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= b;
        s_axis_tlast  <= eos;
        do
            @(posedge i_clk);
        while (!s_axis_tready);
        @(negedge i_clk);
        // random pause before the next offer, none in a tight phase
        gap = tight ? 0 : pick_idle();
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
    endtask

    // stop offering, wait until every escaped byte is out, let the pipe settle
    task automatic drain_block();
        s_axis_tvalid <= 1'b0;
        while (pending_count != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    // escape set changes only once the block is idle
    task automatic set_escape_mode(input logic [1:0] m);
        drain_block();
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= m;
        @(negedge i_clk);
        i_cfg_wr_en   <= 1'b0;
        @(negedge i_clk);
    endtask

    function automatic logic [7:0] pick_special();
        case ($urandom_range(0, 5))
            0:       return CH_AMP;
            1:       return CH_QUOTE;
            2:       return CH_APOS;
            3:       return CH_LT;
            4:       return CH_GT;
            default: return CH_BSLASH;
        endcase
    endfunction

    // reset released at a falling edge
    initial begin
        repeat (4) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
    end

    // receiver: bursts of ready with random stalls, plus one long hold-off
    initial begin
        int k;
        @(posedge i_rst_n);
        @(negedge i_clk);
        forever begin
            if (squeeze_req && !squeeze_done) begin
                // the sender keeps offering, so the block backs up and drops tready
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(negedge i_clk);
                squeeze_done = 1'b1;
            end else begin
                m_axis_tready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(negedge i_clk);
                k = pick_idle();
                if (k > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (k) @(negedge i_clk);
                end
            end
        end
    end

    // sender and verdict
    initial begin
        int sent;
        int n;
        int r;
        logic [7:0] b;
        tight = 1'b0;
        @(posedge i_rst_n);
        @(negedge i_clk);

        // html entities, multibyte flag set, cleared by a continuation and by end of string
        set_escape_mode(MODE_HTML);
        send_text_byte(8'h00, 1'b0);
        send_text_byte(8'hFF, 1'b0);
        send_text_byte(CH_AMP, 1'b0);      // continuation, passes raw
        send_text_byte(CH_QUOTE, 1'b0);
        send_text_byte(CH_APOS, 1'b0);
        send_text_byte(CH_LT, 1'b0);
        send_text_byte(CH_GT, 1'b0);
        send_text_byte(CH_AMP, 1'b0);
        send_text_byte(CH_BSLASH, 1'b0);   // not special here
        send_text_byte(8'h7F, 1'b0);
        send_text_byte(8'hC3, 1'b1);       // lead byte ending a string
        send_text_byte(CH_LT, 1'b0);       // flag already gone, so escaped
        send_text_byte(8'h80, 1'b0);
        send_text_byte(CH_GT, 1'b0);       // continuation, passes raw

        // string inside html
        set_escape_mode(MODE_STR_HTML);
        send_text_byte(CH_QUOTE, 1'b0);
        send_text_byte(CH_BSLASH, 1'b0);
        send_text_byte(CH_LT, 1'b1);

        // plain string, less-than untouched
        set_escape_mode(MODE_STR);
        send_text_byte(CH_QUOTE, 1'b0);
        send_text_byte(CH_BSLASH, 1'b0);
        send_text_byte(CH_LT, 1'b0);

        // unused code, nothing escaped
        set_escape_mode(MODE_RAW);
        send_text_byte(CH_AMP, 1'b0);
        send_text_byte(CH_QUOTE, 1'b0);
        send_text_byte(CH_BSLASH, 1'b0);
        send_text_byte(CH_LT, 1'b1);

        // random phases, one escape set each
        for (int p = 0; p < 8; p++) begin
            set_escape_mode(PHASE_MODE[p]);
            tight = ($urandom_range(0, 2) == 0);
            if (p == 1)
                squeeze_req = 1'b1;
            sent = 0;
            while (sent < PHASE_ITEMS) begin
                r = $urandom_range(0, 99);
                if (r < 15) begin
                    // multibyte character: lead and trailing high bytes, then ascii
                    n = $urandom_range(1, 3);
                    for (int i = 0; i < n; i++)
                        send_text_byte(8'h80 | 8'($urandom_range(0, 127)),
                                       $urandom_range(0, 11) == 0);
                    send_text_byte($urandom_range(0, 1) ? pick_special()
                                                        : 8'($urandom_range(0, 127)),
                                   $urandom_range(0, 7) == 0);
                    sent += n + 1;
                end else begin
                    if (r < 45)
                        b = pick_special();
                    else if (r < 70)
                        b = 8'($urandom_range(8'h20, 8'h7E));
                    else if (r < 80)
                        b = 8'h80 | 8'($urandom_range(0, 127));
                    else if (r < 92)
                        b = 8'($urandom_range(0, 127));
                    else
                        b = 8'($urandom_range(0, 255));
                    send_text_byte(b, $urandom_range(0, 9) == 0);
                    sent++;
                end
            end
        end

        drain_block();
        repeat (8) @(negedge i_clk);
        if (fail_count == 0 && pending_count == 0) begin
            $display("Simulation PASSED");
        end else begin
            $display("Simulation FAILED");
        end
        $finish;
    end

    // watchdog, well above the slowest legal run
    initial begin
        #8ms;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

[sim.f]
+incdir+hdl
hdl/tee_pkg.sv
hdl/tee_classify.sv
hdl/tee_emit.sv
hdl/text_escape_encoder.sv
tb/sv/text_escape_encoder_checker.sv
tb/sv/tb_text_escape_encoder.sv
